/* rtl/uafb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uafb_pkg
// Shared constants and types for the USB audio fill / feedback tracker.
// ----------------------------------------------------------------------------
package uafb_pkg;

    typedef logic [1:0] t_req;

    localparam t_req REQ_START  = 2'd0;
    localparam t_req REQ_PACKET = 2'd1;
    localparam t_req REQ_BUFFER = 2'd2;
    localparam t_req REQ_QUERY  = 2'd3;

    // register indexes on the APB port (word address = paddr[4:2])
    localparam logic [2:0] REG_PACKET_BYTES   = 3'd0;
    localparam logic [2:0] REG_BUFFER_BYTES   = 3'd1;
    localparam logic [2:0] REG_THRESHOLD_UP   = 3'd2;
    localparam logic [2:0] REG_THRESHOLD_DOWN = 3'd3;
    localparam logic [2:0] REG_NOMINAL_FB     = 3'd4;

    localparam int FB_W   = 25;
    localparam int FILL_W = 22;
    localparam int DVD_W  = 31;   // non-negative part of the signed fill
    localparam int DVS_W  = 11;   // packet_bytes

    localparam logic [FB_W-1:0]   FB_MAX       = '1;
    localparam logic [FILL_W-1:0] FILL_PKT_MAX = '1;
    localparam logic [31:0]       FILL_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0]       FILL_NEG_MIN = 32'h8000_0000;

endpackage

/* rtl/uafb_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uafb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module uafb_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [uafb_pkg::DVD_W-1:0] i_dividend,
    input  logic [uafb_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [uafb_pkg::DVD_W-1:0] o_quotient
);
    import uafb_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_dvs, n_dvs;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // dividend shifts out of the top of r_quo while quotient bits shift in
    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/usb_audio_fill_feedback.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_audio_fill_feedback
// Playout ring fill tracker and rate feedback for a USB asynchronous audio
// OUT endpoint. Fill in whole packets comes from a serial divider.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// event     in         i_valid / o_stall      i_req_type, i_packet_size, i_high_speed
// result    out        o_valid / i_stall      o_accepted, o_feedback_value,
//                                             o_feedback_word, o_buffer_index,
//                                             o_data_valid, o_fill_packets
// config    in         APB psel/penable/...   paddr, pwdata, prdata
//
// The accepting edge applies the event and starts the bit-serial divide of the
// fill by packet_bytes. S_DIV waits for the divide and captures the quotient;
// S_DONE finishes the feedback and loads the result register, then returns to
// S_IDLE, where the next event is taken.
// o_stall is high from the accepting edge until the result is loaded.
// A result held by i_stall delays loading of the next one; the next event is
// still taken while a finished result waits. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module usb_audio_fill_feedback #(
    parameter int BUFFER_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event channel
    input  logic        i_valid,
    output logic        o_stall,
    input  uafb_pkg::t_req i_req_type,
    input  logic [10:0] i_packet_size,
    input  logic        i_high_speed,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_accepted,
    output logic [24:0] o_feedback_value,
    output logic [31:0] o_feedback_word,
    output logic [5:0]  o_buffer_index,
    output logic        o_data_valid,
    output logic [21:0] o_fill_packets,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import uafb_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(BUFFER_COUNT - 1);
    localparam logic [IDX_W-1:0] IDX_START = IDX_W'(BUFFER_COUNT / 2 + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // configuration registers
    logic [10:0]     r_packet_bytes;
    logic [15:0]     r_buffer_bytes;
    logic [7:0]      r_thr_up;
    logic [7:0]      r_thr_down;
    logic [FB_W-1:0] r_nominal;

    // tracker state
    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_index, n_index;
    logic             r_started, n_started;
    logic             r_dvalid, n_dvalid;
    logic [31:0]      r_fill, n_fill;
    logic [FB_W-1:0]  r_feedback, n_feedback;
    logic [7:0]       r_held_top, n_held_top;
    logic             r_acc, n_acc;
    logic [31:0]      r_word, n_word;
    logic [DVD_W-1:0] r_quo, n_quo;

    // result register
    logic             r_out_valid;
    logic             r_out_acc;
    logic [FB_W-1:0]  r_out_fb;
    logic [31:0]      r_out_word;
    logic [5:0]       r_out_index;
    logic             r_out_dvalid;
    logic [FILL_W-1:0] r_out_fill;

    logic             take_in;
    logic             cfg_wr;
    logic             out_free;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;
    logic [DVS_W-1:0] divisor;
    logic [32:0]      fill_add;
    logic [32:0]      fill_sub;
    logic [IDX_W-1:0] index_inc;
    logic             over_up;
    logic             under_down;
    logic [FB_W-1:0]  fb_dec;
    logic [FB_W-1:0]  fb_inc;
    logic [FILL_W-1:0] fill_pkts;

    assign take_in  = i_valid && (r_state == S_IDLE);
    assign cfg_wr   = psel && penable && pwrite;
    assign out_free = !r_out_valid || !i_stall;
    assign divisor  = (r_packet_bytes == '0) ? DVS_W'(1) : r_packet_bytes;

    assign fill_add  = {r_fill[31], r_fill} + {22'd0, i_packet_size};
    assign fill_sub  = {r_fill[31], r_fill} - {17'd0, r_buffer_bytes};
    assign index_inc = (r_index == IDX_LAST) ? '0 : r_index + 1'b1;

    // negative fill reads as an unbounded quotient
    assign over_up    = r_fill[31] || (r_quo >= DVD_W'(r_thr_up));
    assign under_down = !r_fill[31] && (r_quo <= DVD_W'(r_thr_down));
    assign fb_dec     = (r_nominal == '0) ? '0 : r_nominal - 1'b1;
    assign fb_inc     = (r_nominal == FB_MAX) ? FB_MAX : r_nominal + 1'b1;
    assign fill_pkts  = (r_fill[31] || (r_quo[DVD_W-1:FILL_W] != '0))
                        ? FILL_PKT_MAX : r_quo[FILL_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_index    = r_index;
        n_started  = r_started;
        n_dvalid   = r_dvalid;
        n_fill     = r_fill;
        n_feedback = r_feedback;
        n_held_top = r_held_top;
        n_acc      = r_acc;
        n_word     = r_word;
        n_quo      = r_quo;
        case (r_state)
            S_IDLE: begin
                if (take_in) begin
                    n_state = S_DIV;
                    n_acc   = 1'b0;
                    n_word  = '0;
                    case (i_req_type)
                        REQ_START: begin
                            n_index    = '0;
                            n_started  = 1'b0;
                            n_dvalid   = 1'b0;
                            n_fill     = '0;
                            n_feedback = r_nominal;
                        end
                        REQ_PACKET: begin
                            if (r_started || (r_index == IDX_START)) begin
                                n_started = 1'b1;
                                n_acc     = 1'b1;
                                n_fill    = (fill_add[32] != fill_add[31])
                                            ? FILL_POS_MAX : fill_add[31:0];
                            end
                        end
                        REQ_BUFFER: begin
                            n_index = index_inc;
                            if (r_dvalid) begin
                                n_fill = (fill_sub[32] != fill_sub[31])
                                         ? FILL_NEG_MIN : fill_sub[31:0];
                            end else if (r_started && (index_inc == '0)) begin
                                n_dvalid = 1'b1;
                            end
                        end
                        REQ_QUERY: begin
                            if (i_high_speed) begin
                                n_word = {4'd0, r_feedback[24:21], r_feedback[20:13],
                                          r_feedback[12:0], 3'd0};
                                n_held_top = {4'd0, r_feedback[24:21]};
                            end else begin
                                n_word = {r_held_top, r_feedback[19:0], 4'd0};
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_quo   = div_quo;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    // only a counted packet steers the feedback
                    if (r_acc) begin
                        if (over_up) begin
                            n_feedback = fb_dec;
                        end else if (under_down) begin
                            n_feedback = fb_inc;
                        end else begin
                            n_feedback = r_nominal;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    uafb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (take_in),
        .i_dividend (n_fill[DVD_W-1:0]),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_index    <= '0;
            r_started  <= 1'b0;
            r_dvalid   <= 1'b0;
            r_fill     <= '0;
            r_feedback <= FB_W'(49152);
            r_held_top <= '0;
            r_acc      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_index    <= n_index;
            r_started  <= n_started;
            r_dvalid   <= n_dvalid;
            r_fill     <= n_fill;
            r_feedback <= n_feedback;
            r_held_top <= n_held_top;
            r_acc      <= n_acc;
        end
        r_word <= n_word;
        r_quo  <= n_quo;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_acc    <= r_acc;
            r_out_fb     <= n_feedback;
            r_out_word   <= r_word;
            r_out_index  <= 6'(r_index);
            r_out_dvalid <= r_dvalid;
            r_out_fill   <= fill_pkts;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_bytes <= 11'd384;
            r_buffer_bytes <= 16'd1024;
            r_thr_up       <= 8'd9;
            r_thr_down     <= 8'd4;
            r_nominal      <= FB_W'(49152);
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_PACKET_BYTES:   r_packet_bytes <= pwdata[10:0];
                REG_BUFFER_BYTES:   r_buffer_bytes <= pwdata[15:0];
                REG_THRESHOLD_UP:   r_thr_up       <= pwdata[7:0];
                REG_THRESHOLD_DOWN: r_thr_down     <= pwdata[7:0];
                REG_NOMINAL_FB:     r_nominal      <= pwdata[FB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_PACKET_BYTES:   prdata = {21'd0, r_packet_bytes};
            REG_BUFFER_BYTES:   prdata = {16'd0, r_buffer_bytes};
            REG_THRESHOLD_UP:   prdata = {24'd0, r_thr_up};
            REG_THRESHOLD_DOWN: prdata = {24'd0, r_thr_down};
            REG_NOMINAL_FB:     prdata = {7'd0, r_nominal};
            default:            prdata = '0;
        endcase
    end

    assign pready           = 1'b1;
    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_accepted       = r_out_acc;
    assign o_feedback_value = r_out_fb;
    assign o_feedback_word  = r_out_word;
    assign o_buffer_index   = r_out_index;
    assign o_data_valid     = r_out_dvalid;
    assign o_fill_packets   = r_out_fill;

endmodule
